// ===== src/swept_box_collision_time_macros.svh =====
// Assertion macros shared by the checker of the swept box collision block.
`ifndef SWEPT_BOX_COLLISION_TIME_MACROS_SVH
`define SWEPT_BOX_COLLISION_TIME_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SWC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SWC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define SWC_ASSERT_RAW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/swc_pkg.sv =====
// Shared constants, types and state encodings of the swept box collision block.
package swc_pkg;

  localparam int COORD_BITS   = 32;
  localparam int DIST_BITS    = COORD_BITS + 1;
  localparam int FIELD_COUNT  = 5;
  localparam int IN_DATA_BITS = ((FIELD_COUNT * COORD_BITS + 7) / 8) * 8;

  // Times are signed Q2.16 held in 20 bits; the quotient magnitude has 17 bits
  // plus one bit for the saturated value 2.0.
  localparam int TIME_BITS     = 20;
  localparam int QUO_BITS      = 17;
  localparam int STEP_BITS     = $clog2(QUO_BITS);
  localparam int OUT_TIME_BITS = 17;
  localparam int OUT_USED_BITS = OUT_TIME_BITS + 3;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  localparam logic signed [TIME_BITS-1:0] TIME_NEG_INF = 20'sh80000;
  localparam logic signed [TIME_BITS-1:0] TIME_POS_INF = 20'sh7FFFF;
  localparam logic signed [TIME_BITS-1:0] TIME_ONE     = 20'sd65536;
  localparam logic [QUO_BITS:0]           TIME_TWO     = 18'd131072;
  localparam logic [OUT_TIME_BITS-1:0]    OUT_TIME_ONE = 17'd65536;

  localparam logic [1:0] AXIS_Z      = 2'd2;
  localparam logic [1:0] AXIS_NONE   = 2'd3;
  localparam logic [1:0] NORMAL_NONE = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FOLD
  } swc_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_ABS,
    DV_CHECK,
    DV_STEP,
    DV_FINISH
  } div_state_t;

  typedef struct packed {
    logic       fold;
    logic       close;
    logic [1:0] axis;
    logic       dent_nonneg;
    logic       vel_zero;
  } fold_req_t;

  typedef struct packed {
    logic                     hit;
    logic [OUT_TIME_BITS-1:0] coll_time;
    logic [1:0]               normal_axis;
    logic                     normal_negative;
  } result_t;

endpackage

// ===== src/swc_div.sv =====
// Shift-subtract divider: one quotient bit per cycle, floor to Q2.16, saturated to 2.0.
module swc_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [swc_pkg::DIST_BITS-1:0]  distance,
  input  logic signed [swc_pkg::COORD_BITS-1:0] vel,
  output logic                                  done,
  output logic signed [swc_pkg::TIME_BITS-1:0]  quot
);
  import swc_pkg::*;

  div_state_t state, state_next;

  logic signed [DIST_BITS-1:0]  d_raw;
  logic signed [COORD_BITS-1:0] v_raw;
  logic [DIST_BITS-1:0]         ud;
  logic [COORD_BITS-1:0]        uv;
  logic                         neg;
  logic                         sat;
  logic [DIST_BITS-1:0]         rem;
  logic [QUO_BITS:0]            q;
  logic [STEP_BITS-1:0]         step;

  logic do_abs, do_check, do_step, do_finish;
  logic sat_cond, fits, last_step;
  logic [DIST_BITS-1:0] trial, diff;
  logic signed [TIME_BITS-1:0] qe;

  assign sat_cond  = ud >= {uv, 1'b0};
  assign trial     = (step == '0) ? rem : {rem[DIST_BITS-2:0], 1'b0};
  assign fits      = trial >= {1'b0, uv};
  assign diff      = trial - {1'b0, uv};
  assign last_step = step == STEP_BITS'(QUO_BITS - 1);
  assign qe        = $signed({{(TIME_BITS-QUO_BITS-1){1'b0}}, q});

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE:   if (start) state_next = DV_ABS;
      DV_ABS:    state_next = DV_CHECK;
      DV_CHECK:  state_next = sat_cond ? DV_FINISH : DV_STEP;
      DV_STEP:   if (last_step) state_next = DV_FINISH;
      DV_FINISH: state_next = DV_IDLE;
      default:   state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    do_abs    = 1'b0;
    do_check  = 1'b0;
    do_step   = 1'b0;
    do_finish = 1'b0;
    case (state)
      DV_ABS:    do_abs = 1'b1;
      DV_CHECK:  do_check = 1'b1;
      DV_STEP:   do_step = 1'b1;
      DV_FINISH: do_finish = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        done <= 1'b0;
      end else if (do_finish) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_raw <= distance;
      v_raw <= vel;
    end
    if (do_abs) begin
      ud  <= d_raw[DIST_BITS-1] ? $unsigned(-d_raw) : $unsigned(d_raw);
      uv  <= v_raw[COORD_BITS-1] ? $unsigned(-v_raw) : $unsigned(v_raw);
      neg <= (d_raw != '0) && (d_raw[DIST_BITS-1] ^ v_raw[COORD_BITS-1]);
    end
    if (do_check) begin
      rem  <= ud;
      step <= '0;
      sat  <= sat_cond;
      q    <= sat_cond ? TIME_TWO : '0;
    end
    if (do_step) begin
      rem  <= fits ? diff : trial;
      q    <= {q[QUO_BITS-1:0], fits};
      step <= step + STEP_BITS'(1);
    end
    if (do_finish) begin
      // A negative quotient with a remainder rounds down: -(q + 1) is ~q.
      if (neg) begin
        quot <= ((rem != '0) && !sat) ? ~qe : -qe;
      end else begin
        quot <= qe;
      end
    end
  end

endmodule

// ===== src/swc_fold.sv =====
// Running entry and exit times of a query and the result formed when it closes.
module swc_fold (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swc_pkg::fold_req_t                   req,
  input  logic signed [swc_pkg::TIME_BITS-1:0] ent_q,
  input  logic signed [swc_pkg::TIME_BITS-1:0] ext_q,
  output swc_pkg::result_t                     res
);
  import swc_pkg::*;

  logic signed [TIME_BITS-1:0] best_entry;
  logic signed [TIME_BITS-1:0] least_exit;
  logic [1:0]                  best_axis;
  logic                        best_sign_negative;
  logic                        any_entry_above_one;
  logic                        all_entries_negative;

  logic signed [TIME_BITS-1:0] ent, ext;
  logic signed [TIME_BITS-1:0] best_entry_next, least_exit_next;
  logic [1:0]                  best_axis_next;
  logic                        best_sign_negative_next;
  logic                        any_entry_above_one_next;
  logic                        all_entries_negative_next;
  logic                        take, hit;

  assign ent  = req.vel_zero ? TIME_NEG_INF : ent_q;
  assign ext  = req.vel_zero ? TIME_POS_INF : ext_q;
  assign take = ent >= best_entry;

  always_comb begin
    best_entry_next           = take ? ent : best_entry;
    best_axis_next            = take ? 2'(req.axis + 2'd1) : best_axis;
    best_sign_negative_next   = take ? req.dent_nonneg : best_sign_negative;
    least_exit_next           = (ext < least_exit) ? ext : least_exit;
    any_entry_above_one_next  = any_entry_above_one | (ent > TIME_ONE);
    all_entries_negative_next = all_entries_negative & ent[TIME_BITS-1];
    hit = !(best_entry_next > least_exit_next) && !all_entries_negative_next &&
          !any_entry_above_one_next;
    if (hit) begin
      res.hit             = 1'b1;
      res.coll_time       = best_entry_next[OUT_TIME_BITS-1:0];
      res.normal_axis     = best_axis_next;
      res.normal_negative = best_sign_negative_next;
    end else begin
      res.hit             = 1'b0;
      res.coll_time       = OUT_TIME_ONE;
      res.normal_axis     = NORMAL_NONE;
      res.normal_negative = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (req.fold && req.close)) begin
      best_entry           <= TIME_NEG_INF;
      least_exit           <= TIME_POS_INF;
      best_axis            <= NORMAL_NONE;
      best_sign_negative   <= 1'b0;
      any_entry_above_one  <= 1'b0;
      all_entries_negative <= 1'b1;
    end else if (req.fold) begin
      best_entry           <= best_entry_next;
      least_exit           <= least_exit_next;
      best_axis            <= best_axis_next;
      best_sign_negative   <= best_sign_negative_next;
      any_entry_above_one  <= any_entry_above_one_next;
      all_entries_negative <= all_entries_negative_next;
    end
  end

endmodule

// ===== src/swept_box_collision_time.sv =====
// Top level of the swept box collision block: input capture, divider control and result register.
//
//   Channel   Direction  tdata (low bits first)                       tuser
//   s_*       request in moving_min, moving_max, target_min,          axis
//                        target_max, velocity (32 bits each)
//   m_*       result out collision_time[16:0], normal_axis[18:17],    hit
//                        normal_negative[19], zero pad [23:20]
//
// From acceptance to the next acceptance an axis request passes through the capture,
// magnitude, range check, quotient bit, rounding and fold steps; the 17 quotient
// bits come from the two shift-subtract dividers, which run side by side.
// When both quotients saturate (including zero velocity) the quotient bit steps are
// skipped; a request with axis 3 is dropped in its accepting cycle.
// Reset is synchronous and clears the query state and the valid flag of the result register.
// A z request that finds the previous result still untaken waits in the fold
// step; x and y requests still fold, but no new request is taken while it waits.
module swept_box_collision_time (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // moving_min, moving_max, target_min, target_max, velocity
  input  logic [swc_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // axis
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // collision_time, normal_axis, normal_negative, zero pad
  output logic [swc_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // hit
  output logic                                m_tuser
);
  import swc_pkg::*;

  swc_state_t state, state_next;

  logic signed [COORD_BITS-1:0] moving_min, moving_max, target_min, target_max, velocity;
  logic signed [DIST_BITS-1:0]  d_lo, d_hi, dent, dexit;
  logic                         vel_pos, accept, start;

  logic [1:0] axis_r;
  logic       vel_zero_r;
  logic       dent_nonneg_r;

  logic                        ent_done, ext_done;
  logic signed [TIME_BITS-1:0] ent_q, ext_q;
  logic                        close, fold_en, load_out;
  fold_req_t                   req;
  result_t                     res;
  result_t                     out_r;

  // Unpack the coordinates of one axis request.
  assign moving_min = $signed(s_tdata[COORD_BITS-1:0]);
  assign moving_max = $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);
  assign target_min = $signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
  assign target_max = $signed(s_tdata[4*COORD_BITS-1:3*COORD_BITS]);
  assign velocity   = $signed(s_tdata[5*COORD_BITS-1:4*COORD_BITS]);

  // Distances are one bit wider than coordinates so the difference never wraps.
  assign d_lo    = DIST_BITS'(target_min) - DIST_BITS'(moving_max);
  assign d_hi    = DIST_BITS'(target_max) - DIST_BITS'(moving_min);
  assign vel_pos = !velocity[COORD_BITS-1] && (velocity != '0);
  assign dent    = vel_pos ? d_lo : d_hi;
  assign dexit   = vel_pos ? d_hi : d_lo;

  assign accept = s_tvalid && s_tready;
  assign start  = accept && (s_tuser != AXIS_NONE);
  assign close  = axis_r == AXIS_Z;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_DIV;
      ST_DIV:  if (ent_done && ext_done) state_next = ST_FOLD;
      ST_FOLD: if (fold_en) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    fold_en  = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_FOLD: fold_en = !(close && m_tvalid && !m_tready);
      default: begin
      end
    endcase
  end

  assign load_out = fold_en && close;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      axis_r        <= s_tuser;
      vel_zero_r    <= velocity == '0;
      dent_nonneg_r <= !dent[DIST_BITS-1];
    end
  end

  // Entry and exit quotients are computed in step by two identical dividers.
  swc_div u_div_entry (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .distance (dent),
    .vel      (velocity),
    .done     (ent_done),
    .quot     (ent_q)
  );

  swc_div u_div_exit (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .distance (dexit),
    .vel      (velocity),
    .done     (ext_done),
    .quot     (ext_q)
  );

  always_comb begin
    req.fold        = fold_en;
    req.close       = close;
    req.axis        = axis_r;
    req.dent_nonneg = dent_nonneg_r;
    req.vel_zero    = vel_zero_r;
  end

  swc_fold u_fold (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .ent_q (ent_q),
    .ext_q (ext_q),
    .res   (res)
  );

  // Result register: it holds a finished result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= res;
    end
  end

  assign m_tuser = out_r.hit;
  assign m_tdata = {{(OUT_DATA_BITS-OUT_USED_BITS){1'b0}}, out_r.normal_negative,
                    out_r.normal_axis, out_r.coll_time};

endmodule

// ===== src/swc_checker.sv =====
// Port-level checks of the swept box collision block and their binding to it.
`include "swept_box_collision_time_macros.svh"

module swc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [1:0]                        s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [swc_pkg::OUT_DATA_BITS-1:0] m_tdata,
  input logic                              m_tuser
);
  import swc_pkg::*;

  `SWC_ASSERT_RAW(a_reset_state, rst, !m_tvalid && s_tready, "reset left a result or busy state")
  `SWC_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready && (s_tuser != AXIS_NONE), !s_tready, "request taken while dividing")
  `SWC_ASSERT_IMP(a_miss_format, m_tvalid && !m_tuser, (m_tdata[16:0] == OUT_TIME_ONE) && (m_tdata[19:17] == 3'd0), "miss result not at time one with no normal")
  `SWC_ASSERT_IMP(a_hit_format, m_tvalid && m_tuser, (m_tdata[18:17] != NORMAL_NONE) && (m_tdata[16:0] <= OUT_TIME_ONE), "hit result without normal or past time one")
  `SWC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind swept_box_collision_time swc_checker u_swc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== test/swept_box_collision_time_tb.sv =====
// Self-checking testbench of the swept box collision block: directed and random axis requests.
`timescale 1ns / 1ps

module tb;
  import swc_pkg::*;

  // Q16.16 one, and the two axis codes that the package does not name.
  localparam int         ONE        = 65536;
  localparam logic [1:0] AXIS_X     = 2'd0;
  localparam logic [1:0] AXIS_Y     = 2'd1;
  localparam int         DRAIN      = 60;      // cycles a request may still be in flight
  localparam int         CYCLE_CAP  = 500000;  // hard stop for a hung run
  localparam int         RAND_ITEMS = 800;

  // Scoreboard: follows each query through its axis requests and keeps the result that
  // every closing request must produce, oldest first.
  class collision_scoreboard;
    int         best_entry;
    int         least_exit;
    logic [1:0] best_axis;
    bit         best_negative;
    bit         entry_above_one;
    bit         entries_negative;
    result_t    result_q[$];
    int         errors;
    int         hits;
    int         misses;
    int         ignored;

    function void clear_query();
      best_entry       = int'(TIME_NEG_INF);
      least_exit       = int'(TIME_POS_INF);
      best_axis        = NORMAL_NONE;
      best_negative    = 1'b0;
      entry_above_one  = 1'b0;
      entries_negative = 1'b1;
    endfunction

    // Floor of distance / vel in Q2.16, clamped to +-2.0.
    function int crossing_time(longint distance, longint vel);
      longint unsigned ud, uv, num, q;
      bit              neg;
      ud  = (distance < 0) ? -distance : distance;
      uv  = (vel < 0) ? -vel : vel;
      neg = (distance != 0) && ((distance < 0) != (vel < 0));
      if (ud >= 2 * uv) begin
        q = int'(TIME_TWO);
      end else begin
        num = ud << 16;
        q   = num / uv;
        if (neg && (num % uv) != 0) q++;
      end
      return neg ? -int'(q) : int'(q);
    endfunction

    function void note_request(logic [1:0] axis, logic [IN_DATA_BITS-1:0] data);
      longint  mmin, mmax, tmin, tmax, vel, dent, dexit;
      int      ent, ext;
      result_t res;
      if (axis == AXIS_NONE) begin
        ignored++;
        return;
      end
      mmin = longint'($signed(data[31:0]));
      mmax = longint'($signed(data[63:32]));
      tmin = longint'($signed(data[95:64]));
      tmax = longint'($signed(data[127:96]));
      vel  = longint'($signed(data[159:128]));
      if (vel > 0) begin
        dent  = tmin - mmax;
        dexit = tmax - mmin;
      end else begin
        dent  = tmax - mmin;
        dexit = tmin - mmax;
      end
      if (vel == 0) begin
        ent = int'(TIME_NEG_INF);
        ext = int'(TIME_POS_INF);
      end else begin
        ent = crossing_time(dent, vel);
        ext = crossing_time(dexit, vel);
      end
      // Ties go to the later request.
      if (ent >= best_entry) begin
        best_entry    = ent;
        best_axis     = axis + 2'd1;
        best_negative = (dent >= 0);
      end
      if (ext < least_exit) least_exit = ext;
      if (ent > int'(TIME_ONE)) entry_above_one = 1'b1;
      if (ent >= 0) entries_negative = 1'b0;
      if (axis != AXIS_Z) return;

      if (!(best_entry > least_exit) && !entries_negative && !entry_above_one) begin
        res.hit             = 1'b1;
        res.coll_time       = best_entry[16:0];
        res.normal_axis     = best_axis;
        res.normal_negative = best_negative;
        hits++;
      end else begin
        res.hit             = 1'b0;
        res.coll_time       = OUT_TIME_ONE;
        res.normal_axis     = NORMAL_NONE;
        res.normal_negative = 1'b0;
        misses++;
      end
      result_q.push_back(res);
      clear_query();
    endfunction

    function void check_result(logic [OUT_DATA_BITS-1:0] data, logic hit_flag);
      result_t got, want;
      got.hit             = hit_flag;
      got.coll_time       = data[16:0];
      got.normal_axis     = data[18:17];
      got.normal_negative = data[19];
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: hit %0d time %0d axis %0d neg %0d",
                 $time, got.hit, got.coll_time, got.normal_axis, got.normal_negative);
        return;
      end
      want = result_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch: expected hit %0d time %0d axis %0d neg %0d", $time,
                 want.hit, want.coll_time, want.normal_axis, want.normal_negative);
        $display("%0t:           actual   hit %0d time %0d axis %0d neg %0d", $time,
                 got.hit, got.coll_time, got.normal_axis, got.normal_negative);
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic [1:0]               s_tuser = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     m_tuser;

  collision_scoreboard sb;
  int send_idle;    // percent of cycles the sender holds back
  int recv_stall;   // percent of cycles the receiver refuses a result
  int items_sent;
  int cycles;

  swept_box_collision_time uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver decides each cycle, at the falling edge, whether to take a result.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Results are sampled at the rising edge, where the handshake completes.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Watchdog: a run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Presents one axis request at a falling edge, after a random number of idle cycles,
  // holds it until the block accepts it, and returns at the next falling edge with valid
  // still high so that back-to-back requests keep it up without a glitch.
  task automatic send_item(input logic [1:0] axis, input logic [31:0] mmin,
                           input logic [31:0] mmax, input logic [31:0] tmin,
                           input logic [31:0] tmax, input logic [31:0] vel);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= axis;
    s_tdata  <= {vel, tmax, tmin, mmax, mmin};
    do @(posedge clk); while (!s_tready);
    sb.note_request(axis, {vel, tmax, tmin, mmax, mmin});
    items_sent++;
    @(negedge clk);
  endtask

  // An axis with no motion: entry at minus infinity, exit at plus infinity.
  task automatic send_still(input logic [1:0] axis);
    send_item(axis, 0, ONE, 0, ONE, 0);
  endtask

  function automatic logic [31:0] near_coord();
    return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
  endfunction

  // Boxes near the origin and a velocity of a few units, so that many entries land
  // inside the step; some axes stand still and some creep so slowly that they saturate.
  task automatic send_shaped(input logic [1:0] axis);
    logic [31:0] mmin, tmin, vel;
    int          pick;
    mmin = near_coord();
    tmin = near_coord();
    pick = $urandom_range(9);
    if (pick < 4)
      vel = 0;
    else if (pick == 4)
      vel = ($urandom_range(1) != 0) ? int'($urandom_range(1, 16)) : -int'($urandom_range(1, 16));
    else
      vel = int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
    send_item(axis, mmin, mmin + $urandom_range(0, 2 * ONE), tmin,
              tmin + $urandom_range(0, 2 * ONE), vel);
  endtask

  // One random query: mostly a well-formed x, y, z sequence with shaped content,
  // otherwise axes out of order or fully random fields.
  task automatic send_random_query();
    int kind, count;
    kind = $urandom_range(99);
    if (kind < 75) begin
      send_shaped(AXIS_X);
      if ($urandom_range(19) == 0) send_shaped(AXIS_NONE);
      send_shaped(AXIS_Y);
      send_shaped(AXIS_Z);
    end else if (kind < 88) begin
      count = $urandom_range(1, 4);
      repeat (count) send_shaped(2'($urandom_range(3)));
    end else begin
      count = $urandom_range(1, 3);
      repeat (count) send_item(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                               $urandom);
    end
  endtask

  initial begin
    sb = new;
    sb.clear_query();
    send_idle  = 0;
    recv_stall = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed queries.
    // Plain hit at a quarter step on x, other axes still.
    send_item(AXIS_X, 0, ONE, 2 * ONE, 3 * ONE, 4 * ONE);
    send_still(AXIS_Y);
    send_still(AXIS_Z);
    // Negative velocity on y: entry distance is negative, so the normal points plus.
    send_still(AXIS_X);
    send_item(AXIS_Y, 4 * ONE, 5 * ONE, 0, ONE, -8 * ONE);
    send_still(AXIS_Z);
    // Latest entry (exactly one) comes after the earliest exit: miss.
    send_item(AXIS_X, 0, ONE, 2 * ONE, 3 * ONE, 4 * ONE);
    send_item(AXIS_Y, 0, ONE, 5 * ONE, 6 * ONE, 4 * ONE);
    send_still(AXIS_Z);
    // Boxes already overlap, every entry negative: miss.
    send_item(AXIS_X, 0, 2 * ONE, ONE, 3 * ONE, ONE);
    send_still(AXIS_Y);
    send_still(AXIS_Z);
    // Target out of reach this step, entry saturates above one: miss.
    send_item(AXIS_X, 0, ONE, 10 * ONE, 11 * ONE, ONE);
    send_still(AXIS_Y);
    send_still(AXIS_Z);
    // Field extremes, with an ignored axis-3 request in the middle of the query.
    send_item(AXIS_X, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    send_item(AXIS_Y, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000);
    send_item(AXIS_NONE, '1, '1, '1, '1, '1);
    send_item(AXIS_Z, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    // Equal entry times on x and z: the later axis sets the normal.
    send_item(AXIS_X, 0, ONE, 2 * ONE, 3 * ONE, 2 * ONE);
    send_still(AXIS_Y);
    send_item(AXIS_Z, 0, ONE, 3 * ONE, 4 * ONE, 4 * ONE);
    // A lone z request closes a query by itself; entry exactly one still hits.
    send_item(AXIS_Z, 3 * ONE, 4 * ONE, 0, 2 * ONE, -ONE);
    // A tiny negative quotient must round down and stay negative.
    send_item(AXIS_X, 0, 1, 0, ONE, 3);
    send_item(AXIS_Y, 0, ONE, ONE + ONE / 2, 2 * ONE, ONE);
    send_still(AXIS_Z);

    // Random queries in four handshake phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 49; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 49; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      while (items_sent < 26 + (phase + 1) * RAND_ITEMS / 4) send_random_query();
      if (phase == 1) begin
        // Hold off until the block has handed over every result it owes.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d axis requests (%0d with axis 3) across four handshake phases.",
             items_sent, sb.ignored);
    $display("Checked %0d query results: %0d hits and %0d misses.",
             sb.hits + sb.misses, sb.hits, sb.misses);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
